[design/twpk_pkg.sv]
// Shared types, codes and the compress type lookup for the tile word packer.
package twpk_pkg;

	// class codes as they land in the header
	typedef enum logic [1:0] {
		CLS_BYTE = 2'd0,
		CLS_HALF = 2'd1,
		CLS_WORD = 2'd2,
		CLS_ZERO = 2'd3
	} class_t;

	// result kinds on the output tuser
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_HALF    = 2'd1;
	localparam logic [1:0] KIND_WORD    = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	localparam int unsigned WORDS_PER_TILE = 8;

	// one queue entry: an optional payload beat and an optional summary beat
	typedef struct packed {
		logic        has_pl;
		logic [1:0]  pl_kind;
		logic [31:0] pl_data;
		logic        has_sum;
		logic [15:0] header;
		logic [2:0]  ctype;
		logic [5:0]  bytes;
		logic        blank;
		logic        words_only;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// halfword parity and byte count mod 4 select the type; odd parity with
	// two bytes falls back to type 0
	function automatic logic [2:0] compress_type(input logic h, input logic [1:0] b);
		logic [2:0] t;
		unique case ({h, b})
			3'b000:  t = 3'd0;
			3'b001:  t = 3'd1;
			3'b010:  t = 3'd2;
			3'b011:  t = 3'd3;
			3'b100:  t = 3'd4;
			3'b101:  t = 3'd5;
			3'b110:  t = 3'd0;
			3'b111:  t = 3'd6;
			default: t = 3'd0;
		endcase
		return t;
	endfunction

endpackage

[design/twpk_front.sv]
// Front end: classifies each tile word, keeps per-tile totals, builds queue entries.
module twpk_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [31:0]          tile_word,
	input  logic                 right_side,
	output logic                 push,
	output twpk_pkg::entry_t     push_entry
);
	import twpk_pkg::*;

	logic [2:0]  pos_q;
	logic [15:0] acc_q;
	logic [1:0]  bcnt_q;
	logic        hpar_q;
	logic [5:0]  size_q;
	logic        allz_q;
	logic        nosmall_q;

	class_t      cls;
	logic [31:0] pl_val;
	logic [2:0]  slot;
	logic [15:0] acc_n;
	logic [1:0]  bcnt_n;
	logic        hpar_n;
	logic [5:0]  size_n;
	logic        allz_n;
	logic        nosmall_n;
	logic        tile_end;

	always_comb begin
		cls       = CLS_WORD;
		pl_val    = tile_word;
		bcnt_n    = bcnt_q;
		hpar_n    = hpar_q;
		size_n    = size_q;
		allz_n    = allz_q;
		nosmall_n = nosmall_q;
		priority if (tile_word == 32'd0) begin
			cls    = CLS_ZERO;
			pl_val = 32'd0;
		end else if ((tile_word & (right_side ? 32'hffffff00 : 32'h00ffffff)) == 32'd0) begin
			cls       = CLS_BYTE;
			pl_val    = right_side ? {24'd0, tile_word[7:0]} : {24'd0, tile_word[31:24]};
			bcnt_n    = bcnt_q + 2'd1;
			size_n    = size_q + 6'd1;
			allz_n    = 1'b0;
			nosmall_n = 1'b0;
		end else if ((tile_word & (right_side ? 32'hffff0000 : 32'h0000ffff)) == 32'd0) begin
			cls       = CLS_HALF;
			pl_val    = right_side ? {16'd0, tile_word[15:0]} : {16'd0, tile_word[31:16]};
			hpar_n    = ~hpar_q;
			size_n    = size_q + 6'd2;
			allz_n    = 1'b0;
			nosmall_n = 1'b0;
		end else begin
			size_n = size_q + 6'd4;
			allz_n = 1'b0;
		end
		// first word goes to bits 15:14
		slot  = 3'(WORDS_PER_TILE - 1) - pos_q;
		acc_n = acc_q | (16'(cls) << {slot, 1'b0});
	end

	assign tile_end = (pos_q == 3'(WORDS_PER_TILE - 1));

	always_comb begin
		push_entry.has_pl     = (cls != CLS_ZERO);
		push_entry.pl_kind    = cls;
		push_entry.pl_data    = pl_val;
		push_entry.has_sum    = tile_end;
		push_entry.header     = acc_n;
		push_entry.ctype      = compress_type(hpar_n, bcnt_n);
		push_entry.bytes      = size_n;
		push_entry.blank      = allz_n;
		push_entry.words_only = nosmall_n;
		push = accept && (push_entry.has_pl || push_entry.has_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			acc_q     <= 16'd0;
			bcnt_q    <= 2'd0;
			hpar_q    <= 1'b1;
			size_q    <= 6'd0;
			allz_q    <= 1'b1;
			nosmall_q <= 1'b1;
		end else if (accept) begin
			if (tile_end) begin
				pos_q     <= 3'd0;
				acc_q     <= 16'd0;
				bcnt_q    <= 2'd0;
				hpar_q    <= 1'b1;
				size_q    <= 6'd0;
				allz_q    <= 1'b1;
				nosmall_q <= 1'b1;
			end else begin
				pos_q     <= pos_q + 3'd1;
				acc_q     <= acc_n;
				bcnt_q    <= bcnt_n;
				hpar_q    <= hpar_n;
				size_q    <= size_n;
				allz_q    <= allz_n;
				nosmall_q <= nosmall_n;
			end
		end
	end

endmodule

[design/twpk_queue.sv]
// Short entry queue between the classifier and the output sequencer.
module twpk_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  twpk_pkg::entry_t     push_entry,
	input  logic                 pop,
	output twpk_pkg::entry_t     head,
	output twpk_pkg::q_status_t  status
);
	import twpk_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/twpk_back.sv]
// Back end: splits each entry into its payload beat and summary beat, output register.
module twpk_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  twpk_pkg::entry_t     head,
	input  twpk_pkg::q_status_t  status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           out_kind,
	output logic [31:0]          out_payload,
	output logic [15:0]          out_header,
	output logic [2:0]           out_ctype,
	output logic [5:0]           out_bytes,
	output logic                 out_blank,
	output logic                 out_words_only,
	output logic                 out_last
);
	import twpk_pkg::*;

	logic valid_q;
	logic pl_done_q;
	logic load;
	logic emit_pl;

	assign load    = !status.empty && (!valid_q || out_ready);
	assign emit_pl = head.has_pl && !pl_done_q;
	// entry leaves once its final beat is loaded
	assign pop     = load && !(emit_pl && head.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pl_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q   <= 1'b1;
				pl_done_q <= emit_pl && head.has_sum;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_pl) begin
				out_kind       <= head.pl_kind;
				out_payload    <= head.pl_data;
				out_header     <= 16'd0;
				out_ctype      <= 3'd0;
				out_bytes      <= 6'd0;
				out_blank      <= 1'b0;
				out_words_only <= 1'b0;
				out_last       <= 1'b0;
			end else begin
				out_kind       <= KIND_SUMMARY;
				out_payload    <= 32'd0;
				out_header     <= head.header;
				out_ctype      <= head.ctype;
				out_bytes      <= head.bytes;
				out_blank      <= head.blank;
				out_words_only <= head.words_only;
				out_last       <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;

endmodule

[design/tile_word_size_class_packer.sv]
// Top level of the tile word size-class packer: classifier, queue, output sequencer.
//
//  channel  | dir | tdata                                   | tuser       | tlast
//  s_axis   | in  | tile_word[31:0]                         | right_side  | -
//  m_axis   | out | payload, header, ctype, bytes, flags    | kind[1:0]   | summary
//
// One tile word is taken per cycle while the queue has room; each entry yields
// one or two output beats, one per cycle while m_axis_tready is high; the eighth
// word adds the summary beat. The output register issues at most one beat per cycle.
// Reset clears the tile totals, queue pointers and output valid; no clearing pass.
// A stalled output fills the queue (QUEUE_DEPTH entries) before s_axis_tready drops.
module tile_word_size_class_packer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] tile_word
	input  logic        s_axis_tuser,   // [0] right_side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] payload, [47:32] header_codes, [50:48] compress_type,
	// [56:51] payload_bytes, [57] blank, [58] words_only, [63:59] zero
	output logic [63:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);
	import twpk_pkg::*;

	logic        accept;
	logic        push;
	logic        pop;
	entry_t      push_entry;
	entry_t      head;
	q_status_t   q_stat;
	logic [31:0] o_payload;
	logic [15:0] o_header;
	logic [2:0]  o_ctype;
	logic [5:0]  o_bytes;
	logic        o_blank;
	logic        o_words_only;

	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	twpk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.tile_word  (s_axis_tdata),
		.right_side (s_axis_tuser),
		.push       (push),
		.push_entry (push_entry)
	);

	twpk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_stat)
	);

	twpk_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.status         (q_stat),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_kind       (m_axis_tuser),
		.out_payload    (o_payload),
		.out_header     (o_header),
		.out_ctype      (o_ctype),
		.out_bytes      (o_bytes),
		.out_blank      (o_blank),
		.out_words_only (o_words_only),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, o_words_only, o_blank, o_bytes, o_ctype, o_header, o_payload};

`ifndef ASSERT_OFF
	// a summary beat and tlast go together
	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_SUMMARY)))
		else $error("tlast does not match summary kind");

	// a blank tile has all ZERO class codes and no payload bytes
	a_blank_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast && o_blank) |-> (o_header == 16'hffff && o_bytes == 6'd0))
		else $error("blank summary with payload");

	// a push into a full queue would drop an entry
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("queue overflow");

	// popping needs a head entry
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue underflow");
`endif

endmodule
